[rtl/kli_pkg.sv]
// Package for the keyframe linear interpolator.
// Holds item and result types and the sequencer state codes; no dependencies.
package kli_pkg;

    localparam int unsigned DATA_W = 32;
    localparam int unsigned CNT_W  = 5;
    localparam int unsigned FRAC_W = 16;

    typedef logic signed [DATA_W-1:0] t_data;

    typedef struct packed {
        logic  is_eval;
        t_data time_key;
        t_data point_value;
    } t_item;

    typedef struct packed {
        t_data            curve_value;
        logic [CNT_W-1:0] point_count;
        t_data            first_key;
        t_data            last_key;
        logic             table_full;
    } t_result;

    localparam logic KIND_INSERT = 1'b0;
    localparam logic KIND_EVAL   = 1'b1;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_RD     = 4'd1;
    localparam logic [3:0] S_CMP    = 4'd2;
    localparam logic [3:0] S_SH_RD  = 4'd3;
    localparam logic [3:0] S_SH_WR  = 4'd4;
    localparam logic [3:0] S_WRITE  = 4'd5;
    localparam logic [3:0] S_OVR    = 4'd6;
    localparam logic [3:0] S_RD2    = 4'd7;
    localparam logic [3:0] S_CMP2   = 4'd8;
    localparam logic [3:0] S_DIV    = 4'd9;
    localparam logic [3:0] S_MUL    = 4'd10;
    localparam logic [3:0] S_ADD    = 4'd11;
    localparam logic [3:0] S_DONE   = 4'd12;

endpackage

[rtl/kli_channels.sv]
// Channel interfaces for the keyframe linear interpolator.
// Depends on kli_pkg for the data type.
interface kli_in_if import kli_pkg::*; ();
    logic  valid;
    logic  ready;
    logic  kind;
    t_data time_key;
    t_data point_value;
    modport source (output valid, kind, time_key, point_value, input ready);
    modport sink   (input valid, kind, time_key, point_value, output ready);
endinterface

interface kli_out_if import kli_pkg::*; ();
    logic             valid;
    logic             ready;
    t_data            curve_value;
    logic [CNT_W-1:0] point_count;
    t_data            first_key;
    t_data            last_key;
    logic             table_full;
    modport source (output valid, curve_value, point_count, first_key, last_key, table_full,
                    input ready);
    modport sink   (input valid, curve_value, point_count, first_key, last_key, table_full,
                    output ready);
endinterface

[rtl/kli_front.sv]
// Front end: accepts input beats, classifies them and holds them in a two-entry queue.
// Depends on kli_pkg.
module kli_front import kli_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_ready,
    input  logic  i_kind,
    input  t_data i_time_key,
    input  t_data i_point_value,
    output t_item o_item,
    output logic  o_item_valid,
    input  logic  i_item_pop
);
    t_item      r_q [2];
    logic       r_wr;
    logic       r_rd;
    logic [1:0] r_cnt;
    logic       w_push;

    assign o_ready      = (r_cnt != 2'd2);
    assign w_push       = i_valid && o_ready;
    assign o_item_valid = (r_cnt != 2'd0);
    assign o_item       = r_q[r_rd];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wr].is_eval     <= (i_kind == KIND_EVAL);
            r_q[r_wr].time_key    <= i_time_key;
            r_q[r_wr].point_value <= i_point_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wr <= ~r_wr;
            if (i_item_pop) r_rd <= ~r_rd;
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, i_item_pop};
        end
    end
endmodule

[rtl/kli_div.sv]
// Restoring divider producing a 16-bit fraction num/den with num < den, one bit a cycle.
// Depends on kli_pkg.
module kli_div import kli_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [DATA_W-1:0] i_num,
    input  logic [DATA_W-1:0] i_den,
    output logic              o_done,
    output logic [FRAC_W-1:0] o_quot
);
    logic [DATA_W:0]           r_rem;
    logic [DATA_W-1:0]         r_den;
    logic [FRAC_W-1:0]         r_q;
    logic [$clog2(FRAC_W):0]   r_cnt;
    logic                      r_busy;
    logic                      r_done;
    logic [DATA_W:0]           w_sh;
    logic                      w_ge;

    assign w_sh   = {r_rem[DATA_W-1:0], 1'b0};
    assign w_ge   = (w_sh >= {1'b0, r_den});
    assign o_done = r_done;
    assign o_quot = r_q;

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= {1'b0, i_num};
            r_den <= i_den;
        end else if (r_busy) begin
            r_rem <= w_ge ? (w_sh - {1'b0, r_den}) : w_sh;
            r_q   <= {r_q[FRAC_W-2:0], w_ge};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == ($clog2(FRAC_W)+1)'(FRAC_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end
endmodule

[rtl/kli_back.sv]
// Back end: point table memories, search and shift sequencer, blend arithmetic, result register.
// Depends on kli_pkg and kli_div.
module kli_back import kli_pkg::*; #(
    parameter int unsigned MAX_POINTS = 16
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_item   i_item,
    input  logic    i_item_valid,
    output logic    o_item_pop,
    output t_result o_res,
    output logic    o_res_valid,
    input  logic    i_res_ready
);
    localparam int unsigned CW = $clog2(MAX_POINTS + 1);
    localparam int unsigned IW = $clog2(MAX_POINTS);

    t_data r_key_mem [MAX_POINTS];
    t_data r_val_mem [MAX_POINTS];
    t_data r_rd_key;
    t_data r_rd_val;

    logic [3:0]    r_state;
    logic [CW-1:0] r_n, r_idx, r_pos;
    logic          r_eval;
    t_data         r_t, r_v, r_k1, r_b, r_a, r_cv;
    t_data         r_first, r_last;
    logic          r_drop;
    logic signed [49:0] r_prod;
    t_result       r_res;
    logic          r_res_valid;

    logic [IW-1:0] w_rd_addr, w_wr_addr;
    logic          w_we;
    t_data         w_wr_key, w_wr_val;
    logic          w_key_we;
    logic          w_div_start, w_div_done;
    logic [FRAC_W-1:0] w_quot;
    logic [DATA_W-1:0] w_num, w_den;
    logic signed [DATA_W:0] w_diff;
    logic [CW-1:0] w_idx_nx;
    logic          w_full;

    assign w_full   = (r_n == CW'(MAX_POINTS));
    assign w_idx_nx = r_idx + 1'b1;
    // The divider starts while the lower key is still on the read port.
    assign w_num    = r_t - r_rd_key;
    assign w_den    = r_k1 - r_rd_key;
    assign w_diff   = $signed({r_b[DATA_W-1], r_b}) - $signed({r_a[DATA_W-1], r_a});
    assign w_div_start = (r_state == S_CMP2);

    kli_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_num),
        .i_den   (w_den),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    // Memory port control.
    always_comb begin
        w_rd_addr = r_idx[IW-1:0];
        w_wr_addr = r_pos[IW-1:0];
        w_we      = 1'b0;
        w_key_we  = 1'b0;
        w_wr_key  = r_t;
        w_wr_val  = r_v;
        case (r_state)
            S_SH_RD: w_rd_addr = r_idx[IW-1:0] - 1'b1;
            S_SH_WR: begin
                w_wr_addr = r_idx[IW-1:0];
                w_we      = 1'b1;
                w_key_we  = 1'b1;
                w_wr_key  = r_rd_key;
                w_wr_val  = r_rd_val;
            end
            S_WRITE: begin
                w_we     = 1'b1;
                w_key_we = 1'b1;
            end
            S_OVR:   w_we = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_key_we) r_key_mem[w_wr_addr] <= w_wr_key;
        if (w_we)     r_val_mem[w_wr_addr] <= w_wr_val;
        r_rd_key <= r_key_mem[w_rd_addr];
        r_rd_val <= r_val_mem[w_rd_addr];
    end

    assign o_item_pop  = (r_state == S_IDLE) && i_item_valid;
    assign o_res       = r_res;
    assign o_res_valid = r_res_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_n         <= '0;
            r_first     <= '0;
            r_last      <= '0;
            r_res_valid <= 1'b0;
        end else begin
            if ((r_state == S_DONE) && (!r_res_valid || i_res_ready)) begin
                r_res_valid <= 1'b1;
            end else if (r_res_valid && i_res_ready) begin
                r_res_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: if (i_item_valid) begin
                    r_eval <= i_item.is_eval;
                    r_t    <= i_item.time_key;
                    r_v    <= i_item.point_value;
                    r_idx  <= '0;
                    r_pos  <= '0;
                    r_cv   <= '0;
                    r_drop <= 1'b0;
                    if (r_n == '0) r_state <= i_item.is_eval ? S_DONE : S_WRITE;
                    else           r_state <= S_RD;
                end
                S_RD: r_state <= S_CMP;
                S_CMP: begin
                    if (r_rd_key >= r_t) begin
                        r_pos <= r_idx;
                        r_k1  <= r_rd_key;
                        r_b   <= r_rd_val;
                        if (r_eval) begin
                            if (r_rd_key == r_t || r_idx == '0) begin
                                r_cv    <= r_rd_val;
                                r_state <= S_DONE;
                            end else begin
                                r_idx   <= r_idx - 1'b1;
                                r_state <= S_RD2;
                            end
                        end else if (r_rd_key == r_t) begin
                            r_state <= S_OVR;
                        end else if (w_full) begin
                            r_drop  <= 1'b1;
                            r_state <= S_DONE;
                        end else begin
                            r_idx   <= r_n;
                            r_state <= S_SH_RD;
                        end
                    end else if (w_idx_nx == r_n) begin
                        r_pos <= r_n;
                        if (r_eval) begin
                            r_cv    <= r_rd_val;
                            r_state <= S_DONE;
                        end else if (w_full) begin
                            r_drop  <= 1'b1;
                            r_state <= S_DONE;
                        end else begin
                            r_state <= S_WRITE;
                        end
                    end else begin
                        r_idx   <= w_idx_nx;
                        r_state <= S_RD;
                    end
                end
                S_SH_RD: r_state <= S_SH_WR;
                S_SH_WR: begin
                    r_idx   <= r_idx - 1'b1;
                    r_state <= (r_idx == r_pos + 1'b1) ? S_WRITE : S_SH_RD;
                end
                S_WRITE: begin
                    r_n <= r_n + 1'b1;
                    if (r_pos == '0)  r_first <= r_t;
                    if (r_pos == r_n) r_last  <= r_t;
                    r_state <= S_DONE;
                end
                S_OVR: r_state <= S_DONE;
                S_RD2: r_state <= S_CMP2;
                S_CMP2: begin
                    r_a     <= r_rd_val;
                    r_state <= S_DIV;
                end
                S_DIV: if (w_div_done) r_state <= S_MUL;
                S_MUL: begin
                    r_prod  <= $signed({1'b0, w_quot}) * w_diff;
                    r_state <= S_ADD;
                end
                S_ADD: begin
                    r_cv    <= r_a + DATA_W'(r_prod >>> FRAC_W);
                    r_state <= S_DONE;
                end
                S_DONE: if (!r_res_valid || i_res_ready) begin
                    r_res.curve_value <= r_cv;
                    r_res.point_count <= CNT_W'(r_n);
                    r_res.first_key   <= r_first;
                    r_res.last_key    <= r_last;
                    r_res.table_full  <= r_drop;
                    r_state           <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

[rtl/keyframe_linear_interpolator.sv]
// Top level of the keyframe linear interpolator.
// Depends on kli_pkg, kli_channels, kli_front, kli_back and kli_div.
//
//   Channel    Dir  Beat contents
//   i_item     in   kind, time_key, point_value (signed Q16.16)
//   o_result   out  curve_value, point_count, first_key, last_key, table_full
//
// An item searches the stored keys in order, reading and comparing each stored key it passes.
// An insert of a new key also shifts the keys above it, with a read and a write per moved entry.
// An evaluate between two keys also fetches the lower key, runs the bit-serial divider
// and then the blend, a multiply followed by an add.
// Reset is synchronous and active low; it empties the table, while the key and value
// memories keep whatever they held, since only entries below the count are ever read.
// A two-entry input queue keeps taking beats while a result waits in the output register.
module keyframe_linear_interpolator import kli_pkg::*; #(
    parameter int unsigned MAX_POINTS = 16
) (
    input  logic i_clk,
    input  logic i_rst_n,
    kli_in_if.sink    i_item,
    kli_out_if.source o_result
);
    t_item   w_item;
    logic    w_item_valid;
    logic    w_item_pop;
    t_result w_res;

    // Front end accepts and queues beats.
    kli_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_item.valid),
        .o_ready       (i_item.ready),
        .i_kind        (i_item.kind),
        .i_time_key    (i_item.time_key),
        .i_point_value (i_item.point_value),
        .o_item        (w_item),
        .o_item_valid  (w_item_valid),
        .i_item_pop    (w_item_pop)
    );

    // Back end runs the table search, update and interpolation.
    kli_back #(.MAX_POINTS(MAX_POINTS)) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item       (w_item),
        .i_item_valid (w_item_valid),
        .o_item_pop   (w_item_pop),
        .o_res        (w_res),
        .o_res_valid  (o_result.valid),
        .i_res_ready  (o_result.ready)
    );

    assign o_result.curve_value = w_res.curve_value;
    assign o_result.point_count = w_res.point_count;
    assign o_result.first_key   = w_res.first_key;
    assign o_result.last_key    = w_res.last_key;
    assign o_result.table_full  = w_res.table_full;

    // A dropped insert never carries a curve value.
    a_drop_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result.valid && o_result.table_full) |-> (o_result.curve_value == '0))
        else $error("dropped insert reports a nonzero curve value");

    // A point is only dropped when the table holds its maximum count.
    a_drop_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result.valid && o_result.table_full) |-> (o_result.point_count == CNT_W'(MAX_POINTS)))
        else $error("insert dropped while the table had room");

    // An empty table reports zero keys.
    a_empty_keys: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result.valid && o_result.point_count == '0) |->
            (o_result.first_key == '0 && o_result.last_key == '0))
        else $error("empty table reports nonzero keys");

    // The first key never lies above the last key.
    a_key_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.valid |-> (o_result.first_key <= o_result.last_key))
        else $error("first key above last key");
endmodule

[tb/kli_scoreboard.sv]
`timescale 1ns / 1ps
// Checker for the keyframe linear interpolator: watches both channels, keeps its own
// copy of the point table, predicts each result and compares it. Depends on kli_pkg.
module kli_scoreboard import kli_pkg::*; #(
    parameter int unsigned MAX_POINTS = 16
) (
    input  logic i_clk,
    input  logic i_rst_n,
    kli_in_if.sink    i_item,
    kli_out_if.sink   i_result,
    output int unsigned o_errors,
    output int unsigned o_pending
);

    t_data       keys [MAX_POINTS];
    t_data       vals [MAX_POINTS];
    int unsigned used;
    t_result     expected_q [$];

    function automatic t_data blend(t_data t, t_data t0, t_data t1, t_data a, t_data b);
        longint x;
        longint s;
        x = ((longint'(t) - longint'(t0)) * 65536) / (longint'(t1) - longint'(t0));
        s = (65536 - x) * longint'(a) + x * longint'(b);
        // Shift right on a signed value floors, which is what the curve needs.
        return t_data'(s >>> 16);
    endfunction

    function automatic t_data curve_at(t_data t);
        if (used == 0) return '0;
        if (used == 1 || t <= keys[0]) return vals[0];
        if (t >= keys[used-1]) return vals[used-1];
        for (int i = 1; i < used; i++) begin
            if (t == keys[i]) return vals[i];
            if (t < keys[i]) return blend(t, keys[i-1], keys[i], vals[i-1], vals[i]);
        end
        return vals[used-1];
    endfunction

    // Returns 1 when a new key did not fit.
    function automatic logic store_point(t_data k, t_data v);
        int unsigned pos;
        pos = 0;
        while (pos < used && keys[pos] < k) pos++;
        if (pos < used && keys[pos] == k) begin
            vals[pos] = v;
            return 1'b0;
        end
        if (used >= MAX_POINTS) return 1'b1;
        for (int i = used; i > pos; i--) begin
            keys[i] = keys[i-1];
            vals[i] = vals[i-1];
        end
        keys[pos] = k;
        vals[pos] = v;
        used++;
        return 1'b0;
    endfunction

    assign o_pending = expected_q.size();

    always @(posedge i_clk) begin
        t_result e;
        t_result got;
        if (!i_rst_n) begin
            used = 0;
            expected_q.delete();
            o_errors <= 0;
        end else begin
            // Compare the result beat before predicting, so same-edge beats stay ordered.
            if (i_result.valid && i_result.ready) begin
                got = '{i_result.curve_value, i_result.point_count, i_result.first_key,
                        i_result.last_key, i_result.table_full};
                if (expected_q.size() == 0) begin
                    $display("%0t: unexpected result beat %h", $time, got);
                    o_errors <= o_errors + 1;
                end else begin
                    e = expected_q.pop_front();
                    if (got !== e) begin
                        $display("%0t: mismatch expected %h actual %h", $time, e, got);
                        o_errors <= o_errors + 1;
                    end
                end
            end
            if (i_item.valid && i_item.ready) begin
                e = '0;
                if (i_item.kind == KIND_EVAL) e.curve_value = curve_at(i_item.time_key);
                else e.table_full = store_point(i_item.time_key, i_item.point_value);
                e.point_count = used[CNT_W-1:0];
                if (used > 0) begin
                    e.first_key = keys[0];
                    e.last_key  = keys[used-1];
                end
                expected_q.push_back(e);
            end
        end
    end

endmodule

[tb/tb_keyframe_linear_interpolator.sv]
`timescale 1ns / 1ps
// Top of the keyframe linear interpolator testbench: clock, reset, beat stimulus and verdict.
// Depends on kli_pkg, kli_channels, the block and kli_scoreboard.
module tb_keyframe_linear_interpolator;
    import kli_pkg::*;

    logic i_clk;
    logic i_rst_n;
    int unsigned errors;
    int unsigned pending;
    int unsigned send_idle_pct;
    int unsigned recv_stall_pct;

    kli_in_if  item_ch ();
    kli_out_if result_ch ();

    keyframe_linear_interpolator uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_item(item_ch.sink), .o_result(result_ch.source)
    );

    kli_scoreboard checker_i (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_item(item_ch.sink), .i_result(result_ch.sink),
        .o_errors(errors), .o_pending(pending)
    );

    always begin
        i_clk = 1'b1; #5;
        i_clk = 1'b0; #5;
    end

    // The receiver stalls at random; it changes its ready only on falling edges.
    always @(negedge i_clk) begin
        result_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Drive one beat: optional idle gap, then hold valid until the block takes it.
    // Valid stays high afterwards so the next beat can follow at once; an idle gap
    // or wait_drained drops it.
    task automatic send_beat(logic kind, t_data t, t_data v);
        while ($urandom_range(99) < send_idle_pct) begin
            item_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        item_ch.valid       <= 1'b1;
        item_ch.kind        <= kind;
        item_ch.time_key    <= t;
        item_ch.point_value <= v;
        do @(posedge i_clk); while (!item_ch.ready);
        @(negedge i_clk);
    endtask

    // Keys are mostly taken from a small pool so overwrites, exact hits and a full
    // table all happen often; the rest are fully random 32-bit words.
    function automatic t_data pick_key();
        case ($urandom_range(3))
            0:       return t_data'($urandom);
            1:       return t_data'(($urandom_range(40) - 20) * 65536);
            default: return t_data'(($urandom_range(63) - 32) * 4096 + $urandom_range(3));
        endcase
    endfunction

    task automatic random_phase(int unsigned n);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(2) == 0) send_beat(KIND_INSERT, pick_key(), t_data'($urandom));
            else send_beat(KIND_EVAL, pick_key(), t_data'($urandom));
        end
    endtask

    task automatic wait_drained();
        item_ch.valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
    endtask

    // Emptying the table is only possible by reset, so the small-table cases come first.
    initial begin
        item_ch.valid = 1'b0;
        item_ch.kind = KIND_INSERT;
        item_ch.time_key = '0;
        item_ch.point_value = '0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        i_rst_n = 1'b0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: empty table, one point, exact hit, both clamps, extreme values,
        // wide spans, overwrite, then filling the table and dropping a new key.
        send_beat(KIND_EVAL, 32'sh7fffffff, 32'sh12345678);
        send_beat(KIND_INSERT, 32'sh80000000, 32'sh7fffffff);
        send_beat(KIND_EVAL, 32'sh7fffffff, '0);
        send_beat(KIND_INSERT, 32'sh7fffffff, 32'sh80000000);
        send_beat(KIND_EVAL, 32'sh00000000, '0);
        send_beat(KIND_EVAL, 32'sh7ffffffe, '0);
        send_beat(KIND_EVAL, 32'sh80000001, '0);
        send_beat(KIND_INSERT, 32'sh00010000, 32'sh00050000);
        send_beat(KIND_EVAL, 32'sh00010000, '0);
        send_beat(KIND_EVAL, 32'sh00008000, '0);
        send_beat(KIND_INSERT, 32'sh00010000, 32'shfffb0000);
        send_beat(KIND_EVAL, 32'sh00018000, '0);
        send_beat(KIND_INSERT, 32'sh00010001, 32'sh00000001);
        send_beat(KIND_EVAL, 32'sh80000000, '0);
        for (int i = 0; i < 14; i++)
            send_beat(KIND_INSERT, t_data'(i * 65536 * 3 - 32'sh100000), t_data'($urandom));
        send_beat(KIND_INSERT, 32'sh7fffff00, '1);
        send_beat(KIND_INSERT, 32'sh7fffffff, 32'sh00001234);

        // Random phases with the idle mixes; the table stays full, dropping and overwriting.
        // The pause after each phase also holds the sender until all results are in.
        send_idle_pct = 32; recv_stall_pct = 65;
        random_phase(430);
        wait_drained();
        send_idle_pct = 65; recv_stall_pct = 32;
        random_phase(430);
        wait_drained();
        send_idle_pct = 0; recv_stall_pct = 0;
        random_phase(430);

        wait_drained();
        repeat (200) @(negedge i_clk);
        if (errors == 0 && pending == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule
